// ===== rtl/zpsr_pkg.sv =====
package zpsr_pkg;

  localparam int TW  = 58;  // PID total, Q16
  localparam int DVW = 44;  // divider dividend and quotient width
  localparam int DSW = 16;  // divisor width

  localparam logic [1:0] ZONE_COARSE  = 2'd0;
  localparam logic [1:0] ZONE_FINE    = 2'd1;
  localparam logic [1:0] ZONE_SETTLED = 2'd2;
  localparam logic [1:0] ZONE_OFF     = 2'd3;
  localparam logic [1:0] ZONE_NONE    = 2'd3;

  localparam logic [2:0] CFG_GAIN_P        = 3'd0;
  localparam logic [2:0] CFG_GAIN_I        = 3'd1;
  localparam logic [2:0] CFG_GAIN_D        = 3'd2;
  localparam logic [2:0] CFG_INTEGRAL_LIM  = 3'd3;
  localparam logic [2:0] CFG_TOL_SMALL     = 3'd4;
  localparam logic [2:0] CFG_TOL_LARGE     = 3'd5;
  localparam logic [2:0] CFG_INTERVAL_SLOW = 3'd6;
  localparam logic [2:0] CFG_INTERVAL_FAST = 3'd7;

  localparam logic [8:0]  TENTHS_INVALID = 9'd511;
  localparam logic [12:0] RECIP_100      = 13'd5243;  // 2^19 / 100, rounded up
  localparam int          RECIP_SHIFT    = 19;
  localparam logic [31:0] DT_MAX         = 32'd1000;
  localparam int          SETTLED_CLAMP  = 1000000;

endpackage

// ===== rtl/zpsr_div.sv =====
module zpsr_div
  import zpsr_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient
);

  localparam int CW = $clog2(DVW);

  logic           busy;
  logic [CW-1:0]  cnt;
  logic [DSW-1:0] rem;
  logic [DSW-1:0] dvs;
  logic [DSW:0]   trial;
  logic           ge;

  // One quotient bit per cycle, restoring.
  assign trial = {rem, quotient[DVW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DVW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= ge ? DSW'(trial - {1'b0, dvs}) : trial[DSW-1:0];
      quotient <= {quotient[DVW-2:0], ge};
    end
  end

endmodule

// ===== rtl/zoned_pid_servo_regulator_top.sv =====
// Channel  Handshake             Word
// in       in_valid / in_ready   now_ms, target_mv, measured_mv, power_off
// out      out_valid / out_ready drive_offset, zone, voltage_matched,
//                                voltage_mismatched, knocking_enabled
// cfg      cfg_we                cfg_index, cfg_data
//
// Power-off and settled ticks go from S_PREP straight to S_OUT; a seeding or
// out-of-range-gap tick skips the PID terms and the slope divide; a fine tick also
// runs the interpolation. The 44-step shared divider (one divide for the slope term,
// two for the interpolation) is used with one shared multiplier.
// Reset is synchronous; it clears the sequencer, the PID and zone state.
// in_ready is high only while the sequencer is idle; a finished word waits in
// the output register, and the next word then waits in S_OUT until out_ready takes it.
module zoned_pid_servo_regulator_top
  import zpsr_pkg::*;
#(
  parameter int MAX_SPEED       = 90,
  parameter int SPEED_FLOOR     = 5,
  parameter int PULSE_SPEED_CAP = 30,
  parameter int PULSE_LENGTH_MS = 50,
  parameter int STUCK_TIMEOUT   = 2000,
  parameter int BOOST_MAX       = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       now_ms,
  input  logic [14:0]       target_mv,
  input  logic [14:0]       measured_mv,
  input  logic              power_off,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] drive_offset,
  output logic [1:0]        zone,
  output logic              voltage_matched,
  output logic              voltage_mismatched,
  output logic              knocking_enabled,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [30:0]       cfg_data
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHK   = 5'd1;
  localparam logic [4:0] S_PREP  = 5'd2;
  localparam logic [4:0] S_M1    = 5'd3;
  localparam logic [4:0] S_M2    = 5'd4;
  localparam logic [4:0] S_M3    = 5'd5;
  localparam logic [4:0] S_M4    = 5'd6;
  localparam logic [4:0] S_M5    = 5'd7;
  localparam logic [4:0] S_DW1   = 5'd8;
  localparam logic [4:0] S_ZONE  = 5'd9;
  localparam logic [4:0] S_I1    = 5'd10;
  localparam logic [4:0] S_I2    = 5'd11;
  localparam logic [4:0] S_DW2   = 5'd12;
  localparam logic [4:0] S_I3    = 5'd13;
  localparam logic [4:0] S_I4    = 5'd14;
  localparam logic [4:0] S_DW3   = 5'd15;
  localparam logic [4:0] S_PULSE = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  logic [4:0] state;

  // Configuration registers.
  logic [23:0] gain_p, gain_i, gain_d;
  logic [30:0] integral_limit;
  logic [14:0] tol_small_mv, tol_large_mv;
  logic [15:0] interval_slow_ms, interval_fast_ms;

  // Latched input word.
  logic [31:0] now_r;
  logic [14:0] target_r, meas_r;
  logic        off_r;

  // Regulator state.
  logic signed [31:0] integral_sum;
  logic signed [16:0] previous_error;
  logic [31:0]        last_tick_time, stuck_start_time, pulse_start_time;
  logic               pid_seeded, stuck_armed, pulse_active, pulse_fire_now;
  logic [3:0]         stuck_boost;
  logic [1:0]         previous_zone;
  logic [8:0]         target_tenths_seen;
  logic [1:0]         matched_flags;
  logic               knocking;
  logic signed [7:0]  held_drive;

  // Working registers.
  logic [9:0]            dt_r;
  logic signed [TW-1:0]  total;
  logic                  dsign;
  logic                  fwd_r;
  logic [15:0]           ivl_r;
  logic [7:0]            fspd_r;
  logic [1:0]            res_zone;

  // Shared multiplier.
  logic signed [32:0]    mul_a;
  logic signed [24:0]    mul_b;
  logic signed [TW-1:0]  mul_w, mul_p;

  // Shared divider.
  logic           div_start, div_done;
  logic [DVW-1:0] div_n, div_q;
  logic [DSW-1:0] div_d;

  logic signed [15:0] err;
  logic [15:0]        aerr_w;
  logic [14:0]        aerr;
  logic               settled, fine;
  logic [27:0]        tprod;
  logic [8:0]         tenths;
  logic [31:0]        dt32;
  logic [15:0]        xl;
  logic [15:0]        span;
  logic signed [17:0] diff;
  logic [TW-1:0]      mul_mag;
  logic signed [33:0] acc, lim34;
  logic signed [33:0] iclamp;
  logic [TW-1:0]      tot_mag;
  logic [41:0]        raw;
  logic [7:0]         speed;
  logic signed [17:0] ivl_s;
  logic signed [9:0]  fs;
  logic [7:0]         fspd_w;
  logic [31:0]        sst;
  logic [3:0]         boost0, boost_n;
  logic [8:0]         spd_sum;
  logic [7:0]         spd_c;
  logic               stuck_fire;

  assign in_ready = (state == S_IDLE) && !rst;

  assign err    = $signed({1'b0, target_r}) - $signed({1'b0, meas_r});
  assign aerr_w = err[15] ? 16'(-err) : 16'(err);
  assign aerr   = aerr_w[14:0];
  assign settled = aerr <= tol_small_mv;
  assign fine    = aerr <= tol_large_mv;
  // Divide by 100 through a reciprocal; exact for all 15-bit targets.
  assign tprod  = target_r * RECIP_100;
  assign tenths = tprod[27:RECIP_SHIFT];
  assign dt32   = now_r - last_tick_time;
  assign xl     = {1'b0, aerr} - {1'b0, tol_small_mv};
  assign span   = {1'b0, tol_large_mv} - {1'b0, tol_small_mv};
  assign diff   = 18'(err) - 18'(previous_error);
  assign mul_mag = mul_p[TW-1] ? TW'(-mul_p) : TW'(mul_p);

  assign acc   = 34'(integral_sum) + 34'(mul_p);
  assign lim34 = $signed({3'b0, integral_limit});
  assign iclamp = (acc > lim34) ? lim34 : ((acc < -lim34) ? -lim34 : acc);

  assign tot_mag = total[TW-1] ? TW'(-total) : TW'(total);
  assign raw     = tot_mag[TW-1:16];

  always_comb begin
    if (raw > 42'(MAX_SPEED)) speed = 8'(MAX_SPEED);
    else speed = raw[7:0];
    if (speed < 8'(SPEED_FLOOR)) speed = 8'(SPEED_FLOOR);
  end

  // Stuck timer for the coarse zone.
  assign sst        = stuck_armed ? stuck_start_time : now_r;
  assign boost0     = stuck_armed ? stuck_boost : 4'd0;
  assign stuck_fire = (now_r - sst) > 32'(STUCK_TIMEOUT);
  assign boost_n    = ({1'b0, boost0} + 5'd1 < 5'(BOOST_MAX)) ? boost0 + 4'd1
                                                              : 4'(BOOST_MAX);
  assign spd_sum    = {1'b0, speed} + {5'b0, boost_n};
  assign spd_c      = stuck_fire ? ((spd_sum > 9'(MAX_SPEED)) ? 8'(MAX_SPEED)
                                                              : spd_sum[7:0])
                                 : speed;

  assign ivl_s = $signed({2'b0, interval_slow_ms})
               + (dsign ? -$signed({1'b0, div_q[16:0]}) : $signed({1'b0, div_q[16:0]}));
  assign fs    = 10'(SPEED_FLOOR)
               + (dsign ? -$signed({1'b0, div_q[8:0]}) : $signed({1'b0, div_q[8:0]}));
  always_comb begin
    if (fs < 10'(SPEED_FLOOR)) fspd_w = 8'(SPEED_FLOOR);
    else if (fs > 10'(PULSE_SPEED_CAP)) fspd_w = 8'(PULSE_SPEED_CAP);
    else fspd_w = fs[7:0];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_M1: begin
        mul_a = 33'(err);
        mul_b = $signed({15'b0, dt_r});
      end
      S_M2: begin
        mul_a = 33'(err);
        mul_b = $signed({1'b0, gain_p});
      end
      S_M3: begin
        mul_a = 33'(integral_sum);
        mul_b = $signed({1'b0, gain_i});
      end
      S_M4: begin
        mul_a = 33'(diff);
        mul_b = $signed({1'b0, gain_d});
      end
      S_I1: begin
        mul_a = $signed({17'b0, xl});
        mul_b = 25'($signed({1'b0, interval_fast_ms}) - $signed({1'b0, interval_slow_ms}));
      end
      S_I3: begin
        mul_a = $signed({17'b0, xl});
        mul_b = 25'(PULSE_SPEED_CAP - SPEED_FLOOR);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_w = mul_a * mul_b;

  always_ff @(posedge clk) begin
    mul_p <= mul_w;
  end

  always_comb begin
    div_start = (state == S_M5) || (state == S_I2) || (state == S_I4);
    div_n     = mul_mag[DVW-1:0];
    div_d     = (state == S_M5) ? {6'b0, dt_r} : span;
  end

  zpsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p           <= '0;
      gain_i           <= '0;
      gain_d           <= '0;
      integral_limit   <= 31'd10000000;
      tol_small_mv     <= 15'd20;
      tol_large_mv     <= 15'd200;
      interval_slow_ms <= 16'd500;
      interval_fast_ms <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_P:        gain_p           <= cfg_data[23:0];
        CFG_GAIN_I:        gain_i           <= cfg_data[23:0];
        CFG_GAIN_D:        gain_d           <= cfg_data[23:0];
        CFG_INTEGRAL_LIM:  integral_limit   <= cfg_data;
        CFG_TOL_SMALL:     tol_small_mv     <= cfg_data[14:0];
        CFG_TOL_LARGE:     tol_large_mv     <= cfg_data[14:0];
        CFG_INTERVAL_SLOW: interval_slow_ms <= cfg_data[15:0];
        CFG_INTERVAL_FAST: interval_fast_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r    <= now_ms;
      target_r <= target_mv;
      meas_r   <= measured_mv;
      off_r    <= power_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      integral_sum       <= '0;
      previous_error     <= '0;
      last_tick_time     <= '0;
      pid_seeded         <= 1'b0;
      stuck_armed        <= 1'b0;
      stuck_start_time   <= '0;
      stuck_boost        <= '0;
      pulse_active       <= 1'b0;
      pulse_start_time   <= '0;
      pulse_fire_now     <= 1'b1;
      previous_zone      <= ZONE_NONE;
      target_tenths_seen <= TENTHS_INVALID;
      matched_flags      <= '0;
      knocking           <= 1'b0;
      held_drive         <= '0;
      out_valid          <= 1'b0;
    end else begin
      // In S_OUT the word hand-off below decides out_valid.
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_CHK;
        end
        S_CHK: begin
          // A new tenths-of-a-volt target restarts the regulator.
          if (tenths != target_tenths_seen) begin
            integral_sum       <= '0;
            previous_error     <= '0;
            last_tick_time     <= '0;
            pid_seeded         <= 1'b0;
            knocking           <= 1'b0;
            stuck_armed        <= 1'b0;
            stuck_boost        <= '0;
            pulse_active       <= 1'b0;
            previous_zone      <= ZONE_NONE;
            target_tenths_seen <= tenths;
          end
          state <= S_PREP;
        end
        S_PREP: begin
          if (off_r) begin
            integral_sum   <= '0;
            previous_error <= '0;
            last_tick_time <= '0;
            pid_seeded     <= 1'b0;
            knocking       <= 1'b0;
            stuck_armed    <= 1'b0;
            pulse_active   <= 1'b0;
            held_drive     <= '0;
            res_zone       <= ZONE_OFF;
            state          <= S_OUT;
          end else if (settled) begin
            if (integral_sum > 32'(SETTLED_CLAMP)) integral_sum <= 32'(SETTLED_CLAMP);
            else if (integral_sum < -32'(SETTLED_CLAMP)) integral_sum <= -32'(SETTLED_CLAMP);
            matched_flags <= 2'd1;
            knocking      <= 1'b0;
            stuck_armed   <= 1'b0;
            stuck_boost   <= '0;
            pulse_active  <= 1'b0;
            previous_zone <= ZONE_SETTLED;
            held_drive    <= '0;
            res_zone      <= ZONE_SETTLED;
            state         <= S_OUT;
          end else if (!pid_seeded) begin
            pid_seeded     <= 1'b1;
            last_tick_time <= now_r;
            previous_error <= 17'(err);
            total          <= '0;
            state          <= S_ZONE;
          end else begin
            last_tick_time <= now_r;
            if (dt32 == 32'd0 || dt32 > DT_MAX) begin
              total <= '0;
              state <= S_ZONE;
            end else begin
              dt_r  <= dt32[9:0];
              state <= S_M1;
            end
          end
        end
        S_M1: state <= S_M2;
        S_M2: begin
          integral_sum <= 32'(iclamp);
          state        <= S_M3;
        end
        S_M3: begin
          total <= mul_p;
          state <= S_M4;
        end
        S_M4: begin
          total <= total + mul_p;
          state <= S_M5;
        end
        S_M5: begin
          dsign          <= mul_p[TW-1];
          previous_error <= 17'(err);
          state          <= S_DW1;
        end
        S_DW1: begin
          if (div_done) begin
            total <= dsign ? total - $signed({14'b0, div_q}) : total + $signed({14'b0, div_q});
            state <= S_ZONE;
          end
        end
        S_ZONE: begin
          fwd_r <= total[TW-1];
          if (fine) begin
            knocking      <= 1'b1;
            matched_flags <= 2'd0;
            stuck_armed   <= 1'b0;
            stuck_boost   <= '0;
            if (previous_zone != ZONE_FINE) begin
              pulse_active   <= 1'b0;
              pulse_fire_now <= 1'b1;
            end
            previous_zone <= ZONE_FINE;
            res_zone      <= ZONE_FINE;
            state         <= S_I1;
          end else begin
            knocking         <= 1'b0;
            matched_flags    <= 2'd2;
            pulse_active     <= 1'b0;
            previous_zone    <= ZONE_COARSE;
            stuck_armed      <= 1'b1;
            stuck_start_time <= stuck_fire ? now_r : sst;
            stuck_boost      <= stuck_fire ? boost_n : boost0;
            held_drive       <= total[TW-1] ? -$signed(spd_c) : $signed(spd_c);
            res_zone         <= ZONE_COARSE;
            state            <= S_OUT;
          end
        end
        S_I1: state <= S_I2;
        S_I2: begin
          dsign <= mul_p[TW-1];
          state <= S_DW2;
        end
        S_DW2: begin
          if (div_done) begin
            ivl_r <= ivl_s[15:0];
            state <= S_I3;
          end
        end
        S_I3: state <= S_I4;
        S_I4: begin
          dsign <= mul_p[TW-1];
          state <= S_DW3;
        end
        S_DW3: begin
          if (div_done) begin
            fspd_r <= fspd_w;
            state  <= S_PULSE;
          end
        end
        S_PULSE: begin
          if (pulse_active) begin
            if (now_r - pulse_start_time >= 32'(PULSE_LENGTH_MS)) begin
              pulse_active <= 1'b0;
              held_drive   <= '0;
            end
          end else if (pulse_fire_now || (now_r - pulse_start_time >= {16'b0, ivl_r})) begin
            pulse_active     <= 1'b1;
            pulse_fire_now   <= 1'b0;
            pulse_start_time <= now_r;
            held_drive       <= fwd_r ? -$signed(fspd_r) : $signed(fspd_r);
          end else begin
            held_drive <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      drive_offset       <= held_drive;
      zone               <= res_zone;
      voltage_matched    <= matched_flags[0];
      voltage_mismatched <= matched_flags[1];
      knocking_enabled   <= knocking;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DW1 || state == S_DW2 || state == S_DW3))
    else $error("divider finished outside a wait state");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && zone == ZONE_SETTLED |-> drive_offset == 8'sd0 && voltage_matched)
    else $error("settled word with drive or without match flag");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> knocking_enabled == (zone == ZONE_FINE))
    else $error("knocking flag disagrees with zone");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive_offset <= MAX_SPEED && drive_offset >= -MAX_SPEED)
    else $error("drive beyond speed limit");

  assert property (@(posedge clk) disable iff (rst)
    stuck_boost <= 4'(BOOST_MAX))
    else $error("boost over its cap");

endmodule
